@@ rtl/pcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants of the periodic command scheduler
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int TIME_W  = 40;
    localparam int MS_W    = 32;
    localparam int CNT_W   = $clog2(TIME_W + 1);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  entry_index;
        logic        is_write;
        logic        has_delay;
        logic        has_repeat;
        logic [31:0] delay_ms;
        logic [31:0] repeat_ms;
        logic [31:0] reg_address;
        logic [63:0] write_value;
        logic [39:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic        is_summary;
        logic [3:0]  fired_index;
        logic        fire_is_write;
        logic [31:0] fire_address;
        logic [63:0] fire_value;
        logic [39:0] next_time_ms;
        logic        none_pending;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_MOD,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic capture;
        logic arm_step;
        logic retire;
        logic emit_fire;
        logic emit_sum;
        logic mod_go;
        logic mod_finish;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       fire;
        logic       periodic;
        logic       idx_last;
        logic       mod_done;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/pcs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_ctrl
// sequencer for load, start scan and tick scan of the command table
// ----------------------------------------------------------------------------
module pcs_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire pcs_pkg::sts_t sts,
    output pcs_pkg::cmd_t    cmd
);
    import pcs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.req == REQ_START) begin
                        state_next = ST_START;
                    end else if (sts.req == REQ_TICK) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_START: begin
                if (sts.idx_last) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (sts.fire) begin
                    if (sts.out_free) begin
                        if (sts.periodic) begin
                            state_next = ST_MOD;
                        end else if (sts.idx_last) begin
                            state_next = ST_SUM;
                        end
                    end
                end else if (sts.idx_last) begin
                    state_next = ST_SUM;
                end
            end
            ST_MOD: begin
                if (sts.mod_done) state_next = sts.idx_last ? ST_SUM : ST_SCAN;
            end
            ST_SUM: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_START: begin
                cmd.arm_step = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ST_SCAN: begin
                if (sts.fire) begin
                    if (sts.out_free) begin
                        cmd.emit_fire = 1'b1;
                        if (sts.periodic) begin
                            cmd.mod_go = 1'b1;
                        end else begin
                            cmd.retire  = 1'b1;
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end else begin
                    cmd.retire  = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_MOD: begin
                if (sts.mod_done) begin
                    cmd.mod_finish = 1'b1;
                    cmd.idx_inc    = 1'b1;
                end
            end
            ST_SUM: begin
                cmd.emit_sum = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/pcs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_dp
// command table, due time arithmetic, remainder unit and result register
// ----------------------------------------------------------------------------
module pcs_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pcs_pkg::in_item_t s_data,
    output pcs_pkg::out_item_t m_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire pcs_pkg::cmd_t cmd,
    output pcs_pkg::sts_t      sts
);
    import pcs_pkg::*;

    logic              loaded_reg [ENTRIES];
    logic              armed_reg  [ENTRIES];
    logic [TIME_W-1:0] due_reg    [ENTRIES];
    logic [2:0]        flags_reg  [ENTRIES];
    logic [MS_W-1:0]   delay_reg  [ENTRIES];
    logic [MS_W-1:0]   period_reg [ENTRIES];
    logic [31:0]       addr_reg   [ENTRIES];
    logic [63:0]       value_reg  [ENTRIES];

    logic [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              any_reg;
    logic [TIME_W-1:0] nearest_reg;
    logic [MS_W-1:0]   rem_reg;
    logic [TIME_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [IDX_W-1:0]  ld_idx;
    logic              cur_armed;
    logic [TIME_W-1:0] cur_due;
    logic [2:0]        cur_flags;
    logic [MS_W-1:0]   cur_period;
    logic              fire;
    logic [TIME_W:0]   start_sum;
    logic [TIME_W-1:0] start_due;
    logic [MS_W:0]     trial;
    logic [TIME_W+1:0] nd;
    logic              out_free;
    out_item_t         fire_item;
    out_item_t         sum_item;

    assign ld_idx     = s_data.entry_index[IDX_W-1:0];
    assign cur_armed  = armed_reg[idx_reg];
    assign cur_due    = due_reg[idx_reg];
    assign cur_flags  = flags_reg[idx_reg];
    assign cur_period = period_reg[idx_reg];
    assign fire       = cur_armed && (cur_due <= time_reg);
    assign out_free   = !m_valid_reg || m_ready;

    assign start_sum = {1'b0, time_reg}
                     + (cur_flags[1] ? {{(TIME_W+1-MS_W){1'b0}}, delay_reg[idx_reg]}
                                     : {(TIME_W+1){1'b0}});
    assign start_due = start_sum[TIME_W] ? TIME_MAX : start_sum[TIME_W-1:0];

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign nd    = {2'b00, time_reg} + {{(TIME_W+2-MS_W){1'b0}}, cur_period}
                 - {{(TIME_W+2-MS_W){1'b0}}, rem_reg};

    always_comb begin
        sts.req      = s_data.req_type;
        sts.fire     = fire;
        sts.periodic = cur_flags[2] && (cur_period != '0);
        sts.idx_last = (idx_reg == IDX_W'(ENTRIES - 1));
        sts.mod_done = (cnt_reg == '0);
        sts.out_free = out_free;
    end

    always_comb begin
        fire_item               = '0;
        fire_item.fired_index   = 4'(idx_reg);
        fire_item.fire_is_write = cur_flags[0];
        fire_item.fire_address  = addr_reg[idx_reg];
        fire_item.fire_value    = cur_flags[0] ? value_reg[idx_reg] : 64'd0;
        sum_item                = '0;
        sum_item.is_summary     = 1'b1;
        sum_item.next_time_ms   = any_reg ? nearest_reg : '0;
        sum_item.none_pending   = !any_reg;
        sum_item.last           = 1'b1;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                loaded_reg[i] <= 1'b0;
                armed_reg[i]  <= 1'b0;
            end
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                idx_reg <= '0;
                if (s_data.req_type == REQ_LOAD) begin
                    loaded_reg[ld_idx] <= 1'b1;
                    armed_reg[ld_idx]  <= 1'b0;
                end
            end
            if (cmd.idx_inc) idx_reg <= idx_reg + 1'b1;
            if (cmd.arm_step) armed_reg[idx_reg] <= loaded_reg[idx_reg];
            if (cmd.retire && fire) armed_reg[idx_reg] <= 1'b0;
            if (cmd.mod_finish && (nd[TIME_W+1:TIME_W] != 2'b00)) begin
                armed_reg[idx_reg] <= 1'b0;
            end
            if (cmd.mod_go) begin
                cnt_reg <= CNT_W'(TIME_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.emit_fire || cmd.emit_sum) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // table payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            time_reg <= s_data.time_ms;
            any_reg  <= 1'b0;
            if (s_data.req_type == REQ_LOAD) begin
                flags_reg[ld_idx]  <= {s_data.has_repeat, s_data.has_delay, s_data.is_write};
                delay_reg[ld_idx]  <= s_data.delay_ms;
                period_reg[ld_idx] <= s_data.repeat_ms;
                addr_reg[ld_idx]   <= s_data.reg_address;
                value_reg[ld_idx]  <= s_data.write_value;
            end
        end
        if (cmd.arm_step && loaded_reg[idx_reg]) due_reg[idx_reg] <= start_due;
        if (cmd.retire && cur_armed && !fire) begin
            if (!any_reg || cur_due < nearest_reg) begin
                nearest_reg <= cur_due;
                any_reg     <= 1'b1;
            end
        end
        if (cmd.mod_finish && (nd[TIME_W+1:TIME_W] == 2'b00)) begin
            due_reg[idx_reg] <= nd[TIME_W-1:0];
            if (!any_reg || nd[TIME_W-1:0] < nearest_reg) begin
                nearest_reg <= nd[TIME_W-1:0];
                any_reg     <= 1'b1;
            end
        end
        if (cmd.mod_go) begin
            rem_reg <= '0;
            dvd_reg <= time_reg - cur_due;
        end else if (cnt_reg != '0) begin
            rem_reg <= (trial >= {1'b0, cur_period}) ? MS_W'(trial - {1'b0, cur_period})
                                                     : trial[MS_W-1:0];
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
        end
        if (cmd.emit_fire) begin
            m_data_reg <= fire_item;
        end else if (cmd.emit_sum) begin
            m_data_reg <= sum_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_fire || cmd.emit_sum) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");
    a_finish_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_finish |-> (cnt_reg == '0))
        else $error("remainder used before done");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_finish |-> (rem_reg < cur_period))
        else $error("remainder not below period");
`endif

endmodule
`default_nettype wire

@@ rtl/periodic_command_scheduler_top.sv @@
`default_nettype none
// a load is captured in the idle state; a start arms one entry per cycle across the table
// a tick scans one entry per cycle while the output is free and no remainder is running,
// then emits the summary; each fired repeating entry waits in the bit-serial remainder unit
// the next item is taken in idle, which a tick reaches once its summary is registered
// reset: synchronous active-low aresetn clears loaded and armed bits and the output valid
// ----------------------------------------------------------------------------
// periodic_command_scheduler_top
// table of timed register commands fired on time ticks
// ----------------------------------------------------------------------------
module periodic_command_scheduler_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pcs_pkg::in_item_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pcs_pkg::out_item_t  m_data
);
    import pcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
`default_nettype wire
